### sv/sis_pkg.sv
// Package: shared constants and codes of the sorted integer set.
`default_nettype none
package sis_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned CNT_W_DEF    = $clog2(CAPACITY_DEF + 1);
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned REQ_W        = 2;
  localparam int unsigned STATUS_W     = 2;

  typedef enum logic [REQ_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_DECIDE,
    S_UP,
    S_INS,
    S_DOWN,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

### sv/sis_if.sv
// Interfaces: request and response channels of the sorted integer set.
`default_nettype none
interface sis_req_if import sis_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [VAL_W-1:0] item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface sis_rsp_if import sis_pkg::*; #(
  parameter int unsigned CNT_W = CNT_W_DEF
) ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    member_count;
  logic                is_empty;

  modport source (output valid, output status, output member_count, output is_empty,
                  input ready);
  modport sink   (input valid, input status, input member_count, input is_empty,
                  output ready);
endinterface
`default_nettype wire

### sv/sis_mem.sv
// Entry memory: one write port, one read port, registered read data.
`default_nettype none
module sis_mem import sis_pkg::*; #(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(CAPACITY_DEF)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [VAL_W-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [VAL_W-1:0] rdata_o
);

  logic [VAL_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### sv/sis_ctrl.sv
// Sequencer: binary search over the memory, then shift up or down to insert or remove.
`default_nettype none
module sis_ctrl import sis_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned CNT_W    = $clog2(CAPACITY_DEF + 1),
  parameter int unsigned AW       = $clog2(CAPACITY_DEF)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  sis_req_if.sink               req,
  output logic                  mem_we_o,
  output logic [AW-1:0]         mem_waddr_o,
  output logic [VAL_W-1:0]      mem_wdata_o,
  output logic                  mem_re_o,
  output logic [AW-1:0]         mem_raddr_o,
  input  wire logic [VAL_W-1:0] mem_rdata_i,
  output logic                  res_valid_o,
  input  wire logic             res_ready_i,
  output status_e               res_status_o,
  output logic [CNT_W-1:0]      res_count_o
);

  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [CNT_W-1:0]        lo_q, lo_d;
  logic [CNT_W-1:0]        hi_q, hi_d;
  logic [CNT_W-1:0]        mid_q, mid_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic                    found_q, found_d;
  logic                    pend_q, pend_d;
  logic [CNT_W-1:0]        pend_addr_q, pend_addr_d;
  logic signed [VAL_W-1:0] key_q, key_d;
  op_e                     op_q, op_d;
  status_e                 status_q, status_d;
  logic [CNT_W:0]          mid_sum;
  logic [CNT_W-1:0]        mid_c;
  logic [CNT_W-1:0]        idx_dec;
  logic [CNT_W-1:0]        idx_inc;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_c   = mid_sum[CNT_W:1];
  assign idx_dec = idx_q - CNT_W'(1);
  assign idx_inc = idx_q + CNT_W'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (req.valid) state_d = S_RD;
      S_RD:     state_d = (lo_q < hi_q) ? S_CMP : S_DECIDE;
      S_CMP:    state_d = S_RD;
      S_DECIDE: begin
        if (op_q == OP_ADD) begin
          state_d = (found_q || cnt_q == CAP) ? S_DONE : S_UP;
        end else if (op_q == OP_REMOVE) begin
          state_d = found_q ? S_DOWN : S_DONE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_UP:     if (idx_q <= lo_q) state_d = S_INS;
      S_INS:    state_d = S_DONE;
      S_DOWN:   if (idx_q >= cnt_q) state_d = S_DONE;
      S_DONE:   if (res_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready   = 1'b0;
    mem_we_o    = pend_q;
    mem_waddr_o = pend_addr_q[AW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = mid_c[AW-1:0];
    res_valid_o = 1'b0;
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    idx_d       = idx_q;
    found_d     = found_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    key_d       = key_q;
    op_d        = op_q;
    status_d    = status_q;
    case (state_q)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          key_d   = req.item_value;
          op_d    = op_e'(req.req_type);
          lo_d    = '0;
          hi_d    = cnt_q;
          found_d = 1'b0;
        end
      end
      S_RD: begin
        if (lo_q < hi_q) begin
          mem_re_o = 1'b1;
          mid_d    = mid_c;
        end
      end
      S_CMP: begin
        if ($signed(mem_rdata_i) < key_q) begin
          lo_d = mid_q + CNT_W'(1);
        end else begin
          hi_d = mid_q;
        end
        if ($signed(mem_rdata_i) == key_q) begin
          found_d = 1'b1;
        end
      end
      S_DECIDE: begin
        status_d = found_q ? ST_DONE : ST_ABSENT;
        idx_d    = cnt_q;
        if (op_q == OP_ADD) begin
          status_d = (!found_q && cnt_q == CAP) ? ST_FULL : ST_DONE;
        end else if (op_q == OP_REMOVE) begin
          idx_d = lo_q + CNT_W'(1);
        end
      end
      S_UP: begin
        if (idx_q > lo_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_dec[AW-1:0];
          pend_d      = 1'b1;
          pend_addr_d = idx_q;
          idx_d       = idx_dec;
        end
      end
      S_INS: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = lo_q[AW-1:0];
        mem_wdata_o = key_q;
        cnt_d       = cnt_q + CNT_W'(1);
      end
      S_DOWN: begin
        if (idx_q < cnt_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q[AW-1:0];
          pend_d      = 1'b1;
          pend_addr_d = idx_dec;
          idx_d       = idx_inc;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign res_status_o = status_q;
  assign res_count_o  = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    idx_q       <= idx_d;
    found_q     <= found_d;
    pend_addr_q <= pend_addr_d;
    key_q       <= key_d;
    op_q        <= op_d;
    status_q    <= status_d;
  end

endmodule
`default_nettype wire

### sv/sorted_integer_set.sv
// Top level of the sorted integer set.
// Holds up to CAPACITY distinct signed 32-bit values in ascending order in one
// synchronous memory. Each request word (add, remove or find) returns one
// response word with status, the count held afterwards and an empty flag.
// A request is accepted in the idle state and then runs a binary search, a read
// state and a compare state per probe. An add of a new value then moves every
// entry at or above the insertion point up by one, one entry per cycle, and a
// remove moves the entries above the hit down by one. The response then passes
// through the output register. One request is handled at a time; the response
// register lets the next request enter while a response waits to be taken.
`default_nettype none
module sorted_integer_set import sis_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sis_req_if.sink   req,
  sis_rsp_if.source rsp
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned AW    = $clog2(CAPACITY);

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_rdata;
  logic             res_valid;
  logic             res_ready;
  status_e          res_status;
  logic [CNT_W-1:0] res_count;

  logic             out_valid_q;
  status_e          out_status_q;
  logic [CNT_W-1:0] out_count_q;

  sis_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W),
    .AW       (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_status_o (res_status),
    .res_count_o  (res_count)
  );

  sis_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || rsp.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_status_q <= res_status;
      out_count_q  <= res_count;
    end
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.status       = out_status_q;
  assign rsp.member_count = out_count_q;
  assign rsp.is_empty     = (out_count_q == '0);

endmodule
`default_nettype wire

### sv/sis_chk.sv
// Checker: port-level properties of the sorted integer set, bound to the top level.
`default_nettype none
module sis_chk import sis_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned CNT_W    = $clog2(CAPACITY_DEF + 1)
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                req_valid_i,
  input wire logic                req_ready_i,
  input wire logic                rsp_valid_i,
  input wire logic                rsp_ready_i,
  input wire logic [STATUS_W-1:0] rsp_status_i,
  input wire logic [CNT_W-1:0]    rsp_member_count_i,
  input wire logic                rsp_is_empty_i
);

  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response word dropped while stalled");

  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous one in progress");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_member_count_i <= CAP)
    else $error("member count above capacity");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_is_empty_i == (rsp_member_count_i == '0))
    else $error("empty flag disagrees with count");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_FULL |-> rsp_member_count_i == CAP)
    else $error("full status with free entries");

endmodule

bind sorted_integer_set sis_chk #(
  .CAPACITY (CAPACITY),
  .CNT_W    (CNT_W)
) u_sis_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req.valid),
  .req_ready_i        (req.ready),
  .rsp_valid_i        (rsp.valid),
  .rsp_ready_i        (rsp.ready),
  .rsp_status_i       (rsp.status),
  .rsp_member_count_i (rsp.member_count),
  .rsp_is_empty_i     (rsp.is_empty)
);
`default_nettype wire

### tb/sorted_integer_set_test.sv
// Testbench: random and directed add/remove/find words against a shadow sorted set.
`timescale 1ns / 1ps
module sorted_integer_set_test;
  import sis_pkg::*;

  localparam logic [REQ_W-1:0] OP_SPARE = 2'd3;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned PHASES = 4;

  typedef struct packed {
    logic [REQ_W-1:0]        kind;
    logic signed [VAL_W-1:0] value;
  } set_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [CNT_W_DEF-1:0] count;
    logic                 empty;
  } set_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                    drv_valid = 1'b0;
  logic [REQ_W-1:0]        drv_kind = OP_FIND;
  logic signed [VAL_W-1:0] drv_value = '0;
  logic                    rsp_ready = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned send_pct_tbl [PHASES] = '{0, 60, 0, 15};
  int unsigned stall_pct_tbl [PHASES] = '{0, 0, 60, 15};

  set_req_t   pending_reqs [$];
  set_reply_t expected_replies [$];

  logic signed [VAL_W-1:0] shadow_vals [CAPACITY_DEF];
  int unsigned shadow_count = 0;

  int unsigned err_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_adds = 0;
  int unsigned n_removes = 0;
  int unsigned n_finds = 0;
  int unsigned n_full = 0;
  int unsigned n_absent = 0;
  int unsigned peak_count = 0;

  set_req_t   next_req;
  set_reply_t predicted;
  set_reply_t want;

  sis_req_if req_ch ();
  sis_rsp_if rsp_ch ();

  assign req_ch.valid      = drv_valid;
  assign req_ch.req_type   = drv_kind;
  assign req_ch.item_value = drv_value;
  assign rsp_ch.ready      = rsp_ready;

  sorted_integer_set #(.CAPACITY(CAPACITY_DEF)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch.sink),
    .rsp    (rsp_ch.source)
  );

  always #1 clk_i = ~clk_i;

  function automatic set_reply_t update_shadow_set(input logic [REQ_W-1:0] kind,
                                                   input logic signed [VAL_W-1:0] value);
    int unsigned pos;
    logic present;
    set_reply_t reply;
    pos = 0;
    while (pos < shadow_count && shadow_vals[pos] < value) pos++;
    present = (pos < shadow_count) && (shadow_vals[pos] == value);
    reply.status = present ? ST_DONE : ST_ABSENT;
    if (kind == OP_ADD && !present) begin
      if (shadow_count >= CAPACITY_DEF) begin
        reply.status = ST_FULL;
      end else begin
        for (int unsigned i = shadow_count; i > pos; i--) shadow_vals[i] = shadow_vals[i-1];
        shadow_vals[pos] = value;
        shadow_count++;
        reply.status = ST_DONE;
      end
    end else if (kind == OP_REMOVE && present) begin
      for (int unsigned i = pos; i + 1 < shadow_count; i++) shadow_vals[i] = shadow_vals[i+1];
      shadow_count--;
    end
    reply.count = shadow_count[CNT_W_DEF-1:0];
    reply.empty = (shadow_count == 0);
    return reply;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned r;
    int k;
    r = $urandom_range(99);
    if (r < 70) begin
      k = int'($urandom_range(79)) - 40;
      return k * 1000003;
    end else if (r < 80) begin
      case ($urandom_range(6))
        0: return 32'sh8000_0000;
        1: return 32'sh8000_0001;
        2: return 32'sh7fff_ffff;
        3: return 32'sh7fff_fffe;
        4: return -32'sd1;
        5: return 32'sd0;
        default: return 32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [REQ_W-1:0] pick_kind(input int unsigned add_w,
                                                 input int unsigned rem_w);
    int unsigned r;
    r = $urandom_range(99);
    if (r < add_w) return OP_ADD;
    if (r < add_w + rem_w) return OP_REMOVE;
    if (r < 95) return OP_FIND;
    return OP_SPARE;
  endfunction

  function automatic void queue_request(input logic [REQ_W-1:0] kind,
                                        input logic signed [VAL_W-1:0] value);
    set_req_t item;
    item.kind = kind;
    item.value = value;
    pending_reqs.push_back(item);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    if (err_count < 50)
      $display("%0t ns: mismatch in %s: expected %0h, got %0h", $realtime, what, exp_v, got_v);
    err_count++;
  endtask

  // driver: predict on acceptance, then present the next word or idle
  always @(posedge clk_i) begin
    if (drv_valid && req_ch.ready) begin
      predicted = update_shadow_set(drv_kind, drv_value);
      expected_replies.push_back(predicted);
      case (drv_kind)
        OP_ADD:    n_adds++;
        OP_REMOVE: n_removes++;
        default:   n_finds++;
      endcase
      if (predicted.status == ST_FULL) n_full++;
      if (predicted.status == ST_ABSENT) n_absent++;
      if (shadow_count > peak_count) peak_count = shadow_count;
    end
    if (!drv_valid || req_ch.ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_reqs.pop_front();
        drv_valid <= 1'b1;
        drv_kind  <= next_req.kind;
        drv_value <= next_req.value;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // monitor: compare each accepted response word with the oldest prediction
  always @(posedge clk_i) begin
    rsp_ready <= ($urandom_range(99) >= stall_pct);
    if (rst_ni && rsp_ch.valid && rsp_ready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected response", 32'h0, {30'h0, rsp_ch.status});
      end else begin
        want = expected_replies.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", want.status, rsp_ch.status);
        if (rsp_ch.member_count !== want.count)
          report_mismatch("member_count", want.count, rsp_ch.member_count);
        if (rsp_ch.is_empty !== want.empty)
          report_mismatch("is_empty", want.empty, rsp_ch.is_empty);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (drv_valid && req_ch.ready) || (rsp_ch.valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    queue_request(OP_FIND, 32'sd0);
    queue_request(OP_REMOVE, 32'sd5);
    queue_request(OP_SPARE, 32'sd0);
    queue_request(OP_ADD, 32'sh8000_0000);
    queue_request(OP_ADD, 32'sh7fff_ffff);
    queue_request(OP_ADD, 32'sd0);
    queue_request(OP_ADD, -32'sd1);
    queue_request(OP_ADD, 32'sd0);
    queue_request(OP_FIND, 32'sh8000_0000);
    queue_request(OP_FIND, 32'sh7fff_ffff);
    queue_request(OP_FIND, 32'sd1);
    queue_request(OP_SPARE, 32'sh7fff_ffff);
    queue_request(OP_REMOVE, -32'sd1);
    queue_request(OP_REMOVE, -32'sd1);
    queue_request(OP_ADD, 32'sh5555_5555);
    queue_request(OP_ADD, 32'shaaaa_aaaa);
    queue_request(OP_REMOVE, 32'sh8000_0000);
    queue_request(OP_REMOVE, 32'sh7fff_ffff);
    queue_request(OP_REMOVE, 32'sd0);
    queue_request(OP_REMOVE, 32'sh5555_5555);
    queue_request(OP_REMOVE, 32'shaaaa_aaaa);
    queue_request(OP_FIND, 32'sh7fff_ffff);

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      // hold until every queued word has been sent and every response has come back
      while (pending_reqs.size() != 0 || expected_replies.size() != 0) @(negedge clk_i);
      send_idle_pct = send_pct_tbl[ph];
      stall_pct = stall_pct_tbl[ph];
      for (int n = 0; n < 140; n++) queue_request(pick_kind(85, 5), pick_value());
      for (int n = 0; n < 85; n++) queue_request(pick_kind(10, 75), pick_value());
    end

    while (pending_reqs.size() != 0 || expected_replies.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d adds, %0d removes, %0d finds over %0d idle/stall phases",
             n_adds, n_removes, n_finds, PHASES);
    $display("full-table refusals %0d, absent results %0d, peak count %0d",
             n_full, n_absent, peak_count);
    if (err_count == 0 && expected_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sorted_integer_set.f
sv/sis_pkg.sv
sv/sis_if.sv
sv/sis_mem.sv
sv/sis_ctrl.sv
sv/sorted_integer_set.sv
sv/sis_chk.sv
tb/sorted_integer_set_test.sv
